FILE: hdl/sfpl_pkg.sv
// ---------------------------------------------------------------------------
// Serial flash page loader package
// Shared constants, payload types and the page entry rule for the loader.
// ---------------------------------------------------------------------------
package sfpl_pkg;

    localparam int PAGE_BYTES  = 32768;
    localparam int BLOCK_BYTES = 64;

    localparam int OFFSET_W = $clog2(PAGE_BYTES);
    localparam int LEN_W    = $clog2(BLOCK_BYTES + 1);
    localparam int BUF_AW   = $clog2(BLOCK_BYTES);
    localparam int TXPOS_W  = $clog2(BLOCK_BYTES + 6);
    localparam int PROG_W   = 23;

    localparam logic [7:0]        OP_ERASE     = 8'h45;
    localparam logic [7:0]        OP_WRITE     = 8'h57;
    localparam logic [7:0]        ACK_BYTE     = 8'h59;
    localparam logic [7:0]        FILL_BYTE    = 8'hFF;
    localparam logic [PROG_W-1:0] PROGRESS_MAX = {PROG_W{1'b1}};

    localparam logic [7:0]  PAGE_COUNT_RST   = 8'd32;
    localparam logic [7:0]  START_PAGE_RST   = 8'd0;
    localparam logic [15:0] BASE_ADDRESS_RST = 16'h8000;
    localparam logic [15:0] EEPROM_START_RST = 16'hB600;
    localparam logic [15:0] EEPROM_END_RST   = 16'hB800;

    localparam logic [2:0] CFG_PAGE_COUNT   = 3'd0;
    localparam logic [2:0] CFG_START_PAGE   = 3'd1;
    localparam logic [2:0] CFG_BASE_ADDRESS = 3'd2;
    localparam logic [2:0] CFG_EEPROM_START = 3'd3;
    localparam logic [2:0] CFG_EEPROM_END   = 3'd4;

    typedef enum logic [1:0] {
        KIND_IMAGE = 2'd0,
        KIND_RESP  = 2'd1,
        KIND_PULL  = 2'd2,
        KIND_START = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_ACCEPT  = 3'd1,
        PH_PENDING = 3'd2,
        PH_WAIT    = 3'd3,
        PH_DONE    = 3'd4,
        PH_ERROR   = 3'd5,
        PH_ORDER   = 3'd6
    } phase_t;

    typedef enum logic {
        CMD_ERASE = 1'b0,
        CMD_WRITE = 1'b1
    } cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] byte_value;
    } in_item_t;

    typedef struct packed {
        logic              tx_valid;
        logic [7:0]        tx_byte;
        logic              tx_last;
        logic [2:0]        status;
        logic [7:0]        current_page;
        logic [PROG_W-1:0] progress_bytes;
    } out_item_t;

    // Phase taken on arrival at a page. The second page of a skipped pair is
    // always taken in, even past the end of the image.
    function automatic phase_t enter_phase(input logic [7:0] page,
                                           input logic       skip,
                                           input logic [7:0] count);
        logic forced;
        forced = skip && (page == 8'd1);
        if (!forced && (page >= count))
            return PH_DONE;
        else if (!page[0])
            return PH_PENDING;
        else
            return PH_ACCEPT;
    endfunction

endpackage

FILE: hdl/sfpl_in_if.sv
// ---------------------------------------------------------------------------
// Loader input channel
// Valid/ready channel that carries one input item per beat.
// ---------------------------------------------------------------------------
interface sfpl_in_if;
    import sfpl_pkg::*;

    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/sfpl_out_if.sv
// ---------------------------------------------------------------------------
// Loader result channel
// Valid/ready channel that carries one result item per beat.
// ---------------------------------------------------------------------------
interface sfpl_out_if;
    import sfpl_pkg::*;

    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/serial_flash_page_loader.sv
// ---------------------------------------------------------------------------
// Serial flash page loader
// Sequences erase and write commands for a paged image over a byte link.
// ---------------------------------------------------------------------------
//   channel   dir  payload                                     beat
//   in_ch     in   kind, byte_value                            one item
//   out_ch    out  tx_valid, tx_byte, tx_last, status,         one result
//                  current_page, progress_bytes
//   cfg       in   cfg_we, cfg_index, cfg_data                 one register
//
// The whole state update is one pass of logic between the state registers and
// the result register, so one item is taken per clock while the result side
// does not stall. A result register parts the two sides; input is taken while the
// result is still held as long as it is being taken in the same cycle.
// Reset is asynchronous; the block buffer is not cleared and needs no pass.
// ---------------------------------------------------------------------------
module serial_flash_page_loader (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    sfpl_in_if.sink     in_ch,
    sfpl_out_if.source  out_ch
);
    import sfpl_pkg::*;

    localparam logic [TXPOS_W-1:0] TXP_OPCODE = TXPOS_W'(0);
    localparam logic [TXPOS_W-1:0] TXP_PAGE   = TXPOS_W'(1);
    localparam logic [TXPOS_W-1:0] TXP_ADDR_H = TXPOS_W'(2);
    localparam logic [TXPOS_W-1:0] TXP_ADDR_L = TXPOS_W'(3);
    localparam logic [TXPOS_W-1:0] TXP_LENGTH = TXPOS_W'(4);
    localparam logic [TXPOS_W-1:0] TXP_DATA   = TXPOS_W'(5);
    localparam logic [OFFSET_W:0]  PAGE_V     = (OFFSET_W + 1)'(PAGE_BYTES);
    localparam logic [LEN_W-1:0]   BLOCK_V    = LEN_W'(BLOCK_BYTES);

    // Configuration registers.
    logic [7:0]  page_count_reg;
    logic [7:0]  start_page_reg;
    logic [15:0] base_address_reg;
    logic [15:0] eeprom_start_reg;
    logic [15:0] eeprom_end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_count_reg   <= PAGE_COUNT_RST;
            start_page_reg   <= START_PAGE_RST;
            base_address_reg <= BASE_ADDRESS_RST;
            eeprom_start_reg <= EEPROM_START_RST;
            eeprom_end_reg   <= EEPROM_END_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PAGE_COUNT:   page_count_reg   <= cfg_data[7:0];
                CFG_START_PAGE:   start_page_reg   <= cfg_data[7:0];
                CFG_BASE_ADDRESS: base_address_reg <= cfg_data;
                CFG_EEPROM_START: eeprom_start_reg <= cfg_data;
                CFG_EEPROM_END:   eeprom_end_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer state.
    logic [BUF_AW-1:0]   byte_in_block_reg,  byte_in_block_next;
    logic [OFFSET_W-1:0] offset_in_page_reg, offset_in_page_next;
    logic [7:0]          page_index_reg,     page_index_next;
    logic [PROG_W-1:0]   progress_reg,       progress_next;
    logic                all_ones_reg,       all_ones_next;
    phase_t              phase_reg,          phase_next;
    cmd_t                cmd_kind_reg,       cmd_kind_next;
    logic [TXPOS_W-1:0]  tx_position_reg,    tx_position_next;
    logic                skip_two_reg,       skip_two_next;

    logic                out_valid_reg;
    out_item_t           out_data_reg;

    logic                in_fire;
    logic [1:0]          kind;
    logic [7:0]          value;
    logic [7:0]          buf_rdata;

    assign in_fire      = in_ch.valid && in_ch.ready;
    assign in_ch.ready  = !out_valid_reg || out_ch.ready;
    assign kind         = in_ch.data.kind;
    assign value        = in_ch.data.byte_value;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_data_reg;

    // Block geometry.
    logic [OFFSET_W:0]  page_rest;
    logic [LEN_W-1:0]   block_len;
    logic [OFFSET_W:0]  offset_sum;
    logic               page_end;
    logic [15:0]        block_addr;
    logic               in_window;
    logic [LEN_W-1:0]   byte_count;
    logic               block_full;
    logic [PROG_W:0]    progress_sum;
    logic [PROG_W-1:0]  progress_add;

    always_comb
    begin
        page_rest    = PAGE_V - {1'b0, offset_in_page_reg};
        block_len    = (page_rest < (OFFSET_W + 1)'(BLOCK_V)) ?
                       page_rest[LEN_W-1:0] : BLOCK_V;
        offset_sum   = {1'b0, offset_in_page_reg} + (OFFSET_W + 1)'(block_len);
        page_end     = offset_sum >= PAGE_V;
        block_addr   = base_address_reg + 16'(offset_in_page_reg);
        in_window    = (block_addr >= eeprom_start_reg) && (block_addr < eeprom_end_reg);
        byte_count   = LEN_W'(byte_in_block_reg) + LEN_W'(1);
        block_full   = byte_count >= block_len;
        progress_sum = {1'b0, progress_reg} + (PROG_W + 1)'(block_len);
        progress_add = progress_sum[PROG_W] ? PROGRESS_MAX : progress_sum[PROG_W-1:0];
    end

    // Command byte for a pull.
    logic       pull_hit;
    logic [7:0] tx_byte;
    logic       tx_last;

    always_comb
    begin
        pull_hit = in_fire && (kind == KIND_PULL) && (phase_reg == PH_PENDING);
        tx_byte  = 8'd0;
        tx_last  = 1'b0;
        if (cmd_kind_reg == CMD_ERASE)
        begin
            tx_byte = (tx_position_reg == TXP_OPCODE) ? OP_ERASE : {1'b0, page_index_reg[7:1]};
            tx_last = tx_position_reg >= TXP_PAGE;
        end
        else
        begin
            case (tx_position_reg)
                TXP_OPCODE: tx_byte = OP_WRITE;
                TXP_PAGE:   tx_byte = page_index_reg;
                TXP_ADDR_H: tx_byte = block_addr[15:8];
                TXP_ADDR_L: tx_byte = block_addr[7:0];
                TXP_LENGTH: tx_byte = 8'(block_len);
                default:    tx_byte = buf_rdata;
            endcase
            tx_last = tx_position_reg >= (TXP_LENGTH + TXPOS_W'(block_len));
        end
    end

    // Next state.
    always_comb
    begin
        logic finish;
        logic enter;
        logic [7:0] page_next_blk;
        logic skip_next_blk;
        phase_t enter_ph;

        byte_in_block_next  = byte_in_block_reg;
        offset_in_page_next = offset_in_page_reg;
        page_index_next     = page_index_reg;
        progress_next       = progress_reg;
        all_ones_next       = all_ones_reg;
        phase_next          = phase_reg;
        cmd_kind_next       = cmd_kind_reg;
        tx_position_next    = tx_position_reg;
        skip_two_next       = skip_two_reg;
        finish              = 1'b0;
        enter               = 1'b0;

        page_next_blk = page_index_reg + 8'd1;
        skip_next_blk = (skip_two_reg && (page_index_reg == 8'd1)) ? 1'b0 : skip_two_reg;

        if (in_fire)
        begin
            case (kind)
                KIND_START:
                begin
                    page_index_next     = start_page_reg;
                    offset_in_page_next = '0;
                    byte_in_block_next  = '0;
                    progress_next       = '0;
                    all_ones_next       = 1'b1;
                    skip_two_next       = 1'b0;
                    tx_position_next    = '0;
                    cmd_kind_next       = CMD_ERASE;
                    enter               = 1'b1;
                end
                KIND_PULL:
                begin
                    if (pull_hit)
                    begin
                        if (tx_last)
                        begin
                            phase_next       = PH_WAIT;
                            tx_position_next = '0;
                        end
                        else
                        begin
                            tx_position_next = tx_position_reg + TXPOS_W'(1);
                        end
                    end
                end
                KIND_IMAGE:
                begin
                    if (phase_reg == PH_ACCEPT)
                    begin
                        byte_in_block_next = BUF_AW'(byte_count);
                        if (value != FILL_BYTE)
                            all_ones_next = 1'b0;
                        if (block_full)
                        begin
                            if (skip_two_reg)
                                finish = 1'b1;
                            else
                            begin
                                progress_next = progress_add;
                                if (in_window || (all_ones_reg && (value == FILL_BYTE)))
                                    finish = 1'b1;
                                else
                                begin
                                    phase_next       = PH_PENDING;
                                    cmd_kind_next    = CMD_WRITE;
                                    tx_position_next = '0;
                                end
                            end
                        end
                    end
                    else if (phase_reg inside {PH_IDLE, PH_ACCEPT, PH_PENDING, PH_WAIT})
                        phase_next = PH_ORDER;
                end
                default:
                begin
                    if (phase_reg == PH_WAIT)
                    begin
                        if (cmd_kind_reg == CMD_ERASE)
                        begin
                            if (value == ACK_BYTE)
                                phase_next = PH_ACCEPT;
                            else if (page_index_reg == 8'd0)
                            begin
                                skip_two_next = 1'b1;
                                phase_next    = PH_ACCEPT;
                            end
                            else
                                phase_next = PH_ERROR;
                        end
                        else if (value == ACK_BYTE)
                            finish = 1'b1;
                        else
                            phase_next = PH_ERROR;
                    end
                    else if (phase_reg inside {PH_IDLE, PH_ACCEPT, PH_PENDING, PH_WAIT})
                        phase_next = PH_ORDER;
                end
            endcase
        end

        if (finish)
        begin
            offset_in_page_next = offset_sum[OFFSET_W-1:0];
            byte_in_block_next  = '0;
            all_ones_next       = 1'b1;
            phase_next          = PH_ACCEPT;
            if (page_end)
            begin
                offset_in_page_next = '0;
                skip_two_next       = skip_next_blk;
                page_index_next     = page_next_blk;
                enter               = 1'b1;
            end
        end

        enter_ph = enter_phase(page_index_next, skip_two_next, page_count_reg);
        if (enter)
        begin
            phase_next = enter_ph;
            if (enter_ph == PH_PENDING)
            begin
                cmd_kind_next    = CMD_ERASE;
                tx_position_next = '0;
            end
        end
    end

    // Result item.
    out_item_t result;

    always_comb
    begin
        result                = '0;
        result.tx_valid       = pull_hit;
        result.tx_byte        = pull_hit ? tx_byte : 8'd0;
        result.tx_last        = pull_hit && tx_last;
        result.status         = phase_next;
        result.current_page   = page_index_next;
        result.progress_bytes = progress_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_in_block_reg  <= '0;
            offset_in_page_reg <= '0;
            page_index_reg     <= '0;
            progress_reg       <= '0;
            all_ones_reg       <= 1'b1;
            phase_reg          <= PH_IDLE;
            cmd_kind_reg       <= CMD_ERASE;
            tx_position_reg    <= '0;
            skip_two_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            byte_in_block_reg  <= byte_in_block_next;
            offset_in_page_reg <= offset_in_page_next;
            page_index_reg     <= page_index_next;
            progress_reg       <= progress_next;
            all_ones_reg       <= all_ones_next;
            phase_reg          <= phase_next;
            cmd_kind_reg       <= cmd_kind_next;
            tx_position_reg    <= tx_position_next;
            skip_two_reg       <= skip_two_next;
            if (in_fire)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            out_data_reg <= result;
        end
    end

    // The read address follows the next command position, so the data byte
    // for a position is already in the read register when that pull arrives.
    logic              buf_we;
    logic [BUF_AW-1:0] buf_raddr;

    assign buf_we    = in_fire && (kind == KIND_IMAGE) && (phase_reg == PH_ACCEPT);
    assign buf_raddr = BUF_AW'(tx_position_next - TXP_DATA);

    sfpl_ram #(
        .WIDTH (8),
        .DEPTH (BLOCK_BYTES)
    ) u_block_buffer (
        .clk   (clk),
        .we    (buf_we),
        .waddr (byte_in_block_reg),
        .wdata (value),
        .raddr (buf_raddr),
        .rdata (buf_rdata)
    );

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ch.ready)
        else $error("input stalled with an empty result register");

    a_wait_position: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_WAIT) |-> (tx_position_reg == '0))
        else $error("command position not cleared while awaiting response");

    a_offset_range: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, offset_in_page_reg} < PAGE_V))
        else $error("block offset beyond the page");

    a_erase_length: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PENDING && cmd_kind_reg == CMD_ERASE)
            |-> (tx_position_reg <= TXP_PAGE))
        else $error("erase command ran past its second byte");

    a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && kind == KIND_START) |=> (progress_reg == '0 && byte_in_block_reg == '0))
        else $error("start beat did not clear progress");

endmodule

FILE: hdl/sfpl_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module sfpl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: dv/serial_flash_page_loader_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Serial flash page loader testbench
// Drives image, response, pull and start beats with random gaps on both
// channels. A scoreboard predicts the command bytes, phase, page and progress
// of every beat and compares each result with the oldest prediction.
// ---------------------------------------------------------------------------
import sfpl_pkg::*;

class loader_scoreboard;
    logic [7:0]         page_count;
    logic [7:0]         start_page;
    logic [15:0]        base_address;
    logic [15:0]        eeprom_start;
    logic [15:0]        eeprom_end;

    logic [7:0]         block_data [BLOCK_BYTES];
    logic [LEN_W-1:0]   byte_count;
    logic [OFFSET_W:0]  block_offset;
    logic [7:0]         page_index;
    logic [PROG_W-1:0]  progress;
    logic               all_ones;
    phase_t             phase;
    cmd_t               command;
    logic [TXPOS_W-1:0] tx_pos;
    logic               skip_pair;

    out_item_t          expected_results [$];
    int                 errors;

    function new();
        errors = 0;
        page_count   = PAGE_COUNT_RST;
        start_page   = START_PAGE_RST;
        base_address = BASE_ADDRESS_RST;
        eeprom_start = EEPROM_START_RST;
        eeprom_end   = EEPROM_END_RST;
        foreach (block_data[i])
            block_data[i] = '0;
        byte_count   = '0;
        block_offset = '0;
        page_index   = '0;
        progress     = '0;
        all_ones     = 1'b1;
        phase        = PH_IDLE;
        command      = CMD_ERASE;
        tx_pos       = '0;
        skip_pair    = 1'b0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] value);
        case (idx)
            CFG_PAGE_COUNT:   page_count   = value[7:0];
            CFG_START_PAGE:   start_page   = value[7:0];
            CFG_BASE_ADDRESS: base_address = value;
            CFG_EEPROM_START: eeprom_start = value;
            CFG_EEPROM_END:   eeprom_end   = value;
            default: ;
        endcase
    endfunction

    function int unsigned block_len();
        int unsigned rest;
        rest = PAGE_BYTES - block_offset;
        return (rest < BLOCK_BYTES) ? rest : BLOCK_BYTES;
    endfunction

    function logic [15:0] block_addr();
        return base_address + block_offset[15:0];
    endfunction

    function void add_progress(int unsigned n);
        logic [PROG_W:0] sum;
        sum = (PROG_W + 1)'(progress + n);
        progress = (sum > PROGRESS_MAX) ? PROGRESS_MAX : sum[PROG_W-1:0];
    endfunction

    function void enter_page();
        // Page 1 of a rejected pair is always taken in, past the image end too.
        if (!(skip_pair && page_index == 8'd1) && page_index >= page_count) begin
            phase = PH_DONE;
        end
        else if (!page_index[0]) begin
            phase   = PH_PENDING;
            command = CMD_ERASE;
            tx_pos  = '0;
        end
        else begin
            phase = PH_ACCEPT;
        end
    endfunction

    function void finish_block();
        block_offset = block_offset + (OFFSET_W + 1)'(block_len());
        byte_count   = '0;
        all_ones     = 1'b1;
        phase        = PH_ACCEPT;
        if (block_offset >= PAGE_BYTES) begin
            block_offset = '0;
            if (skip_pair && page_index == 8'd1)
                skip_pair = 1'b0;
            page_index = page_index + 8'd1;
            enter_page();
        end
    endfunction

    function void take_image(logic [7:0] v);
        int unsigned len;
        logic [15:0] addr;
        block_data[byte_count[BUF_AW-1:0]] = v;
        if (v != FILL_BYTE)
            all_ones = 1'b0;
        byte_count = byte_count + 1'b1;
        len = block_len();
        if (byte_count < len)
            return;
        addr = block_addr();
        if (skip_pair) begin
            finish_block();
        end
        else if (addr >= eeprom_start && addr < eeprom_end) begin
            add_progress(len);
            finish_block();
        end
        else begin
            add_progress(len);
            if (all_ones) begin
                finish_block();
            end
            else begin
                phase   = PH_PENDING;
                command = CMD_WRITE;
                tx_pos  = '0;
            end
        end
    endfunction

    function void take_response(logic [7:0] v);
        if (command == CMD_ERASE) begin
            if (v == ACK_BYTE) begin
                phase = PH_ACCEPT;
            end
            else if (page_index == 8'd0) begin
                skip_pair = 1'b1;
                phase     = PH_ACCEPT;
            end
            else begin
                phase = PH_ERROR;
            end
        end
        else if (v == ACK_BYTE) begin
            finish_block();
        end
        else begin
            phase = PH_ERROR;
        end
    endfunction

    function void pull_byte(inout out_item_t r);
        int unsigned len;
        logic [15:0] addr;
        logic [7:0] b;
        logic last;
        logic [TXPOS_W-1:0] data_pos;
        len  = block_len();
        addr = block_addr();
        if (command == CMD_ERASE) begin
            b    = (tx_pos == 0) ? OP_ERASE : (page_index >> 1);
            last = (tx_pos >= 1);
        end
        else begin
            data_pos = tx_pos - TXPOS_W'(5);
            case (tx_pos)
                'd0:     b = OP_WRITE;
                'd1:     b = page_index;
                'd2:     b = addr[15:8];
                'd3:     b = addr[7:0];
                'd4:     b = len[7:0];
                default: b = block_data[data_pos[BUF_AW-1:0]];
            endcase
            last = (tx_pos >= 4 + len);
        end
        r.tx_valid = 1'b1;
        r.tx_byte  = b;
        r.tx_last  = last;
        if (last) begin
            phase  = PH_WAIT;
            tx_pos = '0;
        end
        else begin
            tx_pos = tx_pos + 1'b1;
        end
    endfunction

    function void note_input(in_item_t item);
        out_item_t r;
        logic live;
        r    = '0;
        live = (phase <= PH_WAIT);
        case (kind_t'(item.kind))
            KIND_START: begin
                page_index   = start_page;
                block_offset = '0;
                byte_count   = '0;
                progress     = '0;
                all_ones     = 1'b1;
                skip_pair    = 1'b0;
                tx_pos       = '0;
                command      = CMD_ERASE;
                enter_page();
            end
            KIND_PULL: begin
                if (phase == PH_PENDING)
                    pull_byte(r);
            end
            KIND_IMAGE: begin
                if (phase == PH_ACCEPT)
                    take_image(item.byte_value);
                else if (live)
                    phase = PH_ORDER;
            end
            default: begin
                if (phase == PH_WAIT)
                    take_response(item.byte_value);
                else if (live)
                    phase = PH_ORDER;
            end
        endcase
        r.status         = phase;
        r.current_page   = page_index;
        r.progress_bytes = progress;
        expected_results.push_back(r);
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            errors++;
        end
    endfunction

    function void check_result(out_item_t got);
        out_item_t want;
        if (expected_results.size() == 0) begin
            $error("result beat with nothing expected: status %0h page %0h",
                   got.status, got.current_page);
            errors++;
            return;
        end
        want = expected_results.pop_front();
        check_field("tx_valid", want.tx_valid, got.tx_valid);
        check_field("tx_byte", want.tx_byte, got.tx_byte);
        check_field("tx_last", want.tx_last, got.tx_last);
        check_field("status", want.status, got.status);
        check_field("current_page", want.current_page, got.current_page);
        check_field("progress_bytes", want.progress_bytes, got.progress_bytes);
    endfunction
endclass

module serial_flash_page_loader_test;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    sfpl_in_if  in_ch ();
    sfpl_out_if out_ch ();

    serial_flash_page_loader dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    loader_scoreboard sb = new();

    bit tx_quiet = 1'b0;
    bit rx_quiet = 1'b0;
    int rx_stall = 0;
    int random_items = 0;

    always #2 clk = ~clk;

    // Result side: check every accepted beat and stall at random.
    always @(posedge clk) begin
        int r;
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
        end
        else begin
            if (out_ch.valid && out_ch.ready)
                sb.check_result(out_ch.data);
            if ($urandom_range(0, 299) == 0)
                rx_quiet = !rx_quiet;
            if (rx_stall > 0) begin
                out_ch.ready <= 1'b0;
                rx_stall--;
            end
            else begin
                out_ch.ready <= 1'b1;
                r = $urandom_range(0, 999);
                if (!rx_quiet && r < 200)
                    rx_stall = $urandom_range(1, 3);
                else if (!rx_quiet && r < 210)
                    rx_stall = $urandom_range(10, 40);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (tx_quiet || r < 60)
            return 0;
        if (r < 97)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic send_item(kind_t k, logic [7:0] v);
        in_item_t item;
        int gap;
        item.kind       = k;
        item.byte_value = v;
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= item;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        sb.note_input(item);
    endtask

    // Holds the sender until every predicted result has been seen.
    task automatic drain();
        in_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.expected_results.size() != 0);
    endtask

    task automatic configure(logic [7:0] pages, logic [7:0] first,
                             logic [15:0] base, logic [15:0] win_lo,
                             logic [15:0] win_hi);
        logic [15:0] values [5];
        values[CFG_PAGE_COUNT]   = {8'd0, pages};
        values[CFG_START_PAGE]   = {8'd0, first};
        values[CFG_BASE_ADDRESS] = base;
        values[CFG_EEPROM_START] = win_lo;
        values[CFG_EEPROM_END]   = win_hi;
        for (int i = 0; i < 5; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= i[2:0];
            cfg_data  <= values[i];
            @(posedge clk);
            sb.write_reg(i[2:0], values[i]);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic configure_random();
        logic [7:0] pages;
        logic [7:0] first;
        logic [15:0] base;
        logic [15:0] win_lo;
        logic [15:0] win_hi;
        int r;
        r = $urandom_range(0, 9);
        pages = (r == 0) ? 8'd0 : (r == 1) ? 8'd255 : 8'($urandom_range(1, 40));
        r = $urandom_range(0, 9);
        if (r < 4)
            first = 8'd0;
        else if (r < 6)
            first = 8'($urandom_range(1, 7));
        else if (r == 6)
            first = 8'd255;
        else if (r == 7)
            first = pages;
        else
            first = 8'($urandom);
        r = $urandom_range(0, 9);
        if (r < 2)
            base = 16'h0000;
        else if (r == 2)
            base = 16'hFFFF;
        else if (r == 3)
            base = 16'hFFC0;
        else
            base = 16'($urandom);
        r = $urandom_range(0, 9);
        if (r < 6) begin
            // Window over one of the first few blocks of the page.
            win_lo = 16'(base + BLOCK_BYTES * $urandom_range(0, 4));
            win_hi = 16'(win_lo + $urandom_range(1, 160));
        end
        else if (r == 6) begin
            win_lo = 16'h0000;
            win_hi = 16'hFFFF;
        end
        else if (r == 7) begin
            win_lo = 16'($urandom);
            win_hi = 16'(win_lo - $urandom_range(0, 100));
        end
        else begin
            win_lo = 16'($urandom);
            win_hi = 16'($urandom);
        end
        configure(pages, first, base, win_lo, win_hi);
    endtask

    // Feeds well-formed traffic that follows the predicted phase, with some
    // stray beats when noisy. Only beats on target_page count, if one is set.
    task automatic run_session(int max_items, bit noisy, int ff_weight,
                               int target_page, output int taken);
        int style;
        int odd_pos;
        logic [7:0] v;
        taken   = 0;
        style   = 0;
        odd_pos = 0;
        while (taken < max_items) begin
            if ($urandom_range(0, 499) == 0)
                tx_quiet = !tx_quiet;
            if (noisy && $urandom_range(0, 99) < 3) begin
                send_item(kind_t'($urandom_range(0, 3)), 8'($urandom));
            end
            else begin
                case (sb.phase)
                    PH_PENDING: send_item(KIND_PULL, 8'($urandom));
                    PH_WAIT: begin
                        v = 8'($urandom);
                        if (v == ACK_BYTE)
                            v = 8'h00;
                        if (!noisy || $urandom_range(0, 99) < 92)
                            v = ACK_BYTE;
                        send_item(KIND_RESP, v);
                    end
                    PH_ACCEPT: begin
                        if (sb.byte_count == 0) begin
                            style   = ($urandom_range(0, 99) < ff_weight) ?
                                      0 : $urandom_range(1, 3);
                            odd_pos = $urandom_range(0, BLOCK_BYTES - 1);
                        end
                        case (style)
                            0: v = FILL_BYTE;
                            1: v = 8'($urandom);
                            2: v = (sb.byte_count == odd_pos) ?
                                   8'($urandom_range(0, 254)) : FILL_BYTE;
                            default: v = sb.byte_count[0] ? 8'h00 : 8'hFF;
                        endcase
                        send_item(KIND_IMAGE, v);
                    end
                    default: begin
                        if (noisy && $urandom_range(0, 9) < 7)
                            send_item(KIND_START, 8'($urandom));
                        else
                            break;
                    end
                endcase
            end
            if (target_page < 0 || sb.page_index == target_page)
                taken++;
            if (noisy && $urandom_range(0, 199) == 0)
                drain();
        end
    endtask

    initial begin
        int taken;
        rst_n        <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_index    <= CFG_PAGE_COUNT;
        cfg_data     <= '0;
        in_ch.valid  <= 1'b0;
        in_ch.data   <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Wrong-phase beats, both erase outcomes on page zero, and the
        // ignored beats of the order-fault phase.
        send_item(KIND_PULL, 8'h00);
        send_item(KIND_IMAGE, 8'hFF);
        send_item(KIND_START, 8'hFF);
        send_item(KIND_RESP, ACK_BYTE);
        send_item(KIND_START, 8'h00);
        send_item(KIND_PULL, 8'hFF);
        send_item(KIND_PULL, 8'h00);
        send_item(KIND_IMAGE, 8'h00);
        send_item(KIND_START, 8'h00);
        send_item(KIND_PULL, 8'h00);
        send_item(KIND_PULL, 8'h00);
        send_item(KIND_RESP, 8'h00);
        send_item(KIND_START, 8'h00);
        send_item(KIND_PULL, 8'h00);
        send_item(KIND_PULL, 8'h00);
        send_item(KIND_RESP, ACK_BYTE);
        send_item(KIND_PULL, 8'h00);
        send_item(KIND_RESP, ACK_BYTE);
        send_item(KIND_IMAGE, 8'h5A);
        send_item(KIND_RESP, 8'hFF);
        send_item(KIND_PULL, 8'h00);
        drain();
        repeat (3) @(posedge clk);
        // A start page past the image end goes straight to done.
        configure(8'd0, 8'd255, 16'hFFFF, 16'h0000, 16'hFFFF);
        send_item(KIND_START, 8'h00);
        send_item(KIND_IMAGE, 8'h00);
        send_item(KIND_RESP, 8'hFF);
        send_item(KIND_PULL, 8'hFF);

        while (random_items < 1400) begin
            drain();
            repeat (3) @(posedge clk);
            configure_random();
            tx_quiet = ($urandom_range(0, 3) == 0);
            send_item(KIND_START, 8'($urandom));
            run_session($urandom_range(80, 400), 1'b1, 30, -1, taken);
            random_items += taken + 1;
        end

        // Rejected erase on page zero with a one-page image: the first
        // blocks of the skipped pair are taken in without progress.
        drain();
        repeat (3) @(posedge clk);
        configure(8'd1, 8'd0, BASE_ADDRESS_RST, EEPROM_START_RST, EEPROM_END_RST);
        tx_quiet = 1'b0;
        send_item(KIND_START, 8'h00);
        send_item(KIND_PULL, 8'h00);
        send_item(KIND_PULL, 8'h00);
        send_item(KIND_RESP, 8'h4E);
        run_session(150, 1'b0, 50, -1, taken);

        // Odd start page: blocks taken in with no erase first, with
        // drops of all-ones blocks and a few writes.
        drain();
        repeat (3) @(posedge clk);
        configure(8'd3, 8'd1, BASE_ADDRESS_RST, EEPROM_START_RST, EEPROM_END_RST);
        send_item(KIND_START, 8'h00);
        run_session(150, 1'b0, 97, -1, taken);

        drain();
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("serial_flash_page_loader: match");
        else
            $display("serial_flash_page_loader: mismatch");
        $finish;
    end

    initial begin
        #100_000_000;
        $display("serial_flash_page_loader: mismatch");
        $finish;
    end

endmodule
